[rtl/core/mtlp_pkg.sv]
// Shared types, constants and helper functions for the trade tick line parser.
// No dependencies; every module of the block imports this package.
package mtlp_pkg;

  localparam int PRICE_FRACTION_DIGITS = 4;

  localparam int CHAR_W   = 8;
  localparam int COL_W    = 8;
  localparam int DATE_W   = 27;
  localparam int HOUR_W   = 7;
  localparam int MINUTE_W = 7;
  localparam int SEC_W    = 27;
  localparam int PRICE_W  = 37;
  localparam int VOLUME_W = 31;
  localparam int CFG_W    = 5;
  localparam int FRAC_W   = 3;
  localparam int DIGIT_W  = 4;
  localparam int POW_W    = 20;
  localparam int TERM_W   = DIGIT_W + POW_W;

  // Sum widths: accumulator times ten plus one weighted digit.
  localparam int SEC_SUM_W    = SEC_W + 4;
  localparam int PRICE_SUM_W  = PRICE_W + 4;
  localparam int VOLUME_SUM_W = VOLUME_W + 4;

  localparam int OUT_DATA_W = DATE_W + HOUR_W + MINUTE_W + SEC_W + PRICE_W + VOLUME_W;

  localparam logic [SEC_W-1:0]    SECOND_MAX = 27'd99999999;
  localparam logic [PRICE_W-1:0]  PRICE_MAX  = 37'd99999999999;
  localparam logic [VOLUME_W-1:0] VOLUME_MAX = 31'h7FFF_FFFF;

  localparam logic [FRAC_W-1:0] SEC_FRAC_DIGITS   = 3'd6;
  localparam logic [FRAC_W-1:0] PRICE_FRAC_DIGITS = FRAC_W'(PRICE_FRACTION_DIGITS);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;

  localparam logic [COL_W-1:0] COL_DATE        = 8'd0;
  localparam logic [COL_W-1:0] COL_DATE_LAST   = 8'd7;
  localparam logic [COL_W-1:0] COL_HOUR        = 8'd9;
  localparam logic [COL_W-1:0] COL_HOUR_LAST   = 8'd10;
  localparam logic [COL_W-1:0] COL_MINUTE      = 8'd12;
  localparam logic [COL_W-1:0] COL_MINUTE_LAST = 8'd13;
  localparam logic [COL_W-1:0] COL_SECOND      = 8'd15;
  localparam logic [COL_W-1:0] COL_SECOND_LAST = 8'd23;
  localparam logic [COL_W-1:0] COL_PRICE       = 8'd25;
  localparam logic [COL_W-1:0] COL_MAX         = 8'd255;

  localparam logic REG_OPEN_HOUR  = 1'b0;
  localparam logic REG_CLOSE_HOUR = 1'b1;

  localparam logic [CFG_W-1:0] OPEN_HOUR_RESET  = 5'd9;
  localparam logic [CFG_W-1:0] CLOSE_HOUR_RESET = 5'd16;

  typedef enum logic [3:0] {
    PH_TIME   = 4'b0001,
    PH_PRICE  = 4'b0010,
    PH_VOLUME = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [DATE_W-1:0]   date;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SEC_W-1:0]    second;
    logic [PRICE_W-1:0]  price;
    logic [VOLUME_W-1:0] volume;
  } line_fields_t;

  typedef struct packed {
    logic [CFG_W-1:0] open_hour;
    logic [CFG_W-1:0] close_hour;
  } hour_window_t;

  function automatic logic [POW_W-1:0] pow10(input logic [FRAC_W-1:0] k);
    case (k)
      3'd0:    pow10 = 20'd1;
      3'd1:    pow10 = 20'd10;
      3'd2:    pow10 = 20'd100;
      3'd3:    pow10 = 20'd1000;
      3'd4:    pow10 = 20'd10000;
      3'd5:    pow10 = 20'd100000;
      3'd6:    pow10 = 20'd1000000;
      default: pow10 = '0;
    endcase
  endfunction

endpackage

[rtl/core/mtlp_cfg_regs.sv]
// Hour window registers of the tick line parser, written through a plain write port.
// Depends on mtlp_pkg.
module mtlp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [mtlp_pkg::CFG_W-1:0]    cfg_data,
  output mtlp_pkg::hour_window_t        window
);
  import mtlp_pkg::*;

  hour_window_t window_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_q.open_hour  <= OPEN_HOUR_RESET;
      window_q.close_hour <= CLOSE_HOUR_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_OPEN_HOUR:  window_q.open_hour  <= cfg_data;
        REG_CLOSE_HOUR: window_q.close_hour <= cfg_data;
        default: ;
      endcase
    end
  end

  assign window = window_q;

endmodule

[rtl/core/mtlp_field_accum.sv]
// Column tracking and field accumulators of the tick line parser.
// One character is folded into the accumulators per transaction. Depends on mtlp_pkg.
module mtlp_field_accum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [mtlp_pkg::CHAR_W-1:0]   line_char,
  input  logic                          end_of_line,
  output mtlp_pkg::line_fields_t        fields_next
);
  import mtlp_pkg::*;

  logic [COL_W-1:0]  column_count;
  logic [COL_W-1:0]  column_count_next;
  line_fields_t      acc;
  line_fields_t      acc_next;
  logic [FRAC_W-1:0] second_fraction_seen;
  logic [FRAC_W-1:0] second_fraction_seen_next;
  logic [FRAC_W-1:0] price_fraction_seen;
  logic [FRAC_W-1:0] price_fraction_seen_next;
  phase_t            field_phase;
  phase_t            field_phase_next;
  logic              field_stopped;
  logic              field_stopped_next;

  logic                    is_digit;
  logic [DIGIT_W-1:0]      digit;
  logic [FRAC_W-1:0]       sec_idx;
  logic [TERM_W-1:0]       sec_term;
  logic [SEC_SUM_W-1:0]    sec_base;
  logic [SEC_SUM_W-1:0]    sec_sum;
  logic [SEC_W-1:0]        sec_sat;
  logic [FRAC_W-1:0]       price_idx;
  logic [TERM_W-1:0]       price_term;
  logic [PRICE_SUM_W-1:0]  price_base;
  logic [PRICE_SUM_W-1:0]  price_sum;
  logic [PRICE_W-1:0]      price_sat;
  logic [VOLUME_SUM_W-1:0] volume_sum;
  logic [VOLUME_W-1:0]     volume_sat;
  logic [CHAR_W-1:0]       char_offset;

  assign is_digit    = line_char inside {[CHAR_ZERO:CHAR_NINE]};
  assign char_offset = line_char - CHAR_ZERO;
  assign digit       = char_offset[DIGIT_W-1:0];

  // Whole digits shift the value up a decade and enter at the units weight;
  // fraction digits enter at a falling weight without a shift.
  always_comb begin
    sec_idx  = (second_fraction_seen == '0) ? SEC_FRAC_DIGITS
                                            : SEC_FRAC_DIGITS - second_fraction_seen;
    sec_term = TERM_W'(digit) * TERM_W'(pow10(sec_idx));
    sec_base = (second_fraction_seen == '0)
             ? (SEC_SUM_W'(acc.second) << 3) + (SEC_SUM_W'(acc.second) << 1)
             : SEC_SUM_W'(acc.second);
    sec_sum  = sec_base + SEC_SUM_W'(sec_term);
    sec_sat  = (sec_sum > SEC_SUM_W'(SECOND_MAX)) ? SECOND_MAX : sec_sum[SEC_W-1:0];

    price_idx  = (price_fraction_seen == '0) ? PRICE_FRAC_DIGITS
                                             : PRICE_FRAC_DIGITS - price_fraction_seen;
    price_term = TERM_W'(digit) * TERM_W'(pow10(price_idx));
    price_base = (price_fraction_seen == '0)
               ? (PRICE_SUM_W'(acc.price) << 3) + (PRICE_SUM_W'(acc.price) << 1)
               : PRICE_SUM_W'(acc.price);
    price_sum  = price_base + PRICE_SUM_W'(price_term);
    price_sat  = (price_sum > PRICE_SUM_W'(PRICE_MAX)) ? PRICE_MAX
                                                       : price_sum[PRICE_W-1:0];

    volume_sum = (VOLUME_SUM_W'(acc.volume) << 3) + (VOLUME_SUM_W'(acc.volume) << 1)
               + VOLUME_SUM_W'(digit);
    volume_sat = (volume_sum > VOLUME_SUM_W'(VOLUME_MAX)) ? VOLUME_MAX
                                                          : volume_sum[VOLUME_W-1:0];
  end

  always_comb begin
    acc_next                  = acc;
    second_fraction_seen_next = second_fraction_seen;
    price_fraction_seen_next  = price_fraction_seen;
    field_phase_next          = field_phase;
    field_stopped_next        = field_stopped;
    column_count_next         = (column_count == COL_MAX) ? column_count : column_count + 1'b1;

    if (field_phase == PH_TIME) begin
      if (column_count inside {COL_DATE, COL_HOUR, COL_MINUTE, COL_SECOND, COL_PRICE}) begin
        field_stopped_next = 1'b0;
      end
      if (column_count == COL_PRICE) begin
        field_phase_next = PH_PRICE;
      end else if (column_count <= COL_DATE_LAST) begin
        if (!field_stopped_next) begin
          if (is_digit) acc_next.date = DATE_W'(acc.date * 10 + DATE_W'(digit));
          else          field_stopped_next = 1'b1;
        end
      end else if (column_count inside {[COL_HOUR:COL_HOUR_LAST]}) begin
        if (!field_stopped_next) begin
          if (is_digit) acc_next.hour = HOUR_W'(acc.hour * 10 + HOUR_W'(digit));
          else          field_stopped_next = 1'b1;
        end
      end else if (column_count inside {[COL_MINUTE:COL_MINUTE_LAST]}) begin
        if (!field_stopped_next) begin
          if (is_digit) acc_next.minute = MINUTE_W'(acc.minute * 10 + MINUTE_W'(digit));
          else          field_stopped_next = 1'b1;
        end
      end else if (column_count inside {[COL_SECOND:COL_SECOND_LAST]}) begin
        if (!field_stopped_next) begin
          if (is_digit) begin
            if (second_fraction_seen == '0) begin
              acc_next.second = sec_sat;
            end else if (second_fraction_seen <= SEC_FRAC_DIGITS) begin
              acc_next.second           = sec_sat;
              second_fraction_seen_next = second_fraction_seen + 1'b1;
            end
          end else if (line_char == CHAR_POINT && second_fraction_seen == '0) begin
            second_fraction_seen_next = FRAC_W'(1);
          end else begin
            field_stopped_next = 1'b1;
          end
        end
      end
    end

    // The price column itself is parsed in the same transaction that leaves the time phase.
    if (field_phase_next == PH_PRICE) begin
      if (line_char == CHAR_COMMA) begin
        field_phase_next = PH_VOLUME;
      end else if (!field_stopped_next) begin
        if (is_digit) begin
          if (price_fraction_seen == '0) begin
            acc_next.price = price_sat;
          end else if (price_fraction_seen <= PRICE_FRAC_DIGITS) begin
            acc_next.price           = price_sat;
            price_fraction_seen_next = price_fraction_seen + 1'b1;
          end
        end else if (line_char == CHAR_POINT && price_fraction_seen == '0) begin
          price_fraction_seen_next = FRAC_W'(1);
        end else begin
          field_stopped_next = 1'b1;
        end
      end
    end else if (field_phase_next == PH_VOLUME) begin
      if (is_digit) acc_next.volume = volume_sat;
      else          field_phase_next = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && end_of_line)) begin
      column_count         <= '0;
      acc                  <= '0;
      second_fraction_seen <= '0;
      price_fraction_seen  <= '0;
      field_phase          <= PH_TIME;
      field_stopped        <= 1'b0;
    end else if (fire) begin
      column_count         <= column_count_next;
      acc                  <= acc_next;
      second_fraction_seen <= second_fraction_seen_next;
      price_fraction_seen  <= price_fraction_seen_next;
      field_phase          <= field_phase_next;
      field_stopped        <= field_stopped_next;
    end
  end

  assign fields_next = acc_next;

endmodule

[rtl/core/mtlp_out_reg.sv]
// Result register of the tick line parser: captures the finished fields and the
// hour window check at line end and holds them until taken. Depends on mtlp_pkg.
module mtlp_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  mtlp_pkg::line_fields_t        fields_next,
  input  mtlp_pkg::hour_window_t        window,
  input  logic                          take,
  output logic                          out_valid,
  output mtlp_pkg::line_fields_t        fields,
  output logic                          tick_valid
);
  import mtlp_pkg::*;

  logic in_window;

  assign in_window = (fields_next.hour > HOUR_W'(window.open_hour))
                  && (fields_next.hour < HOUR_W'(window.close_hour))
                  && (fields_next.price != '0)
                  && (fields_next.volume != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fields     <= fields_next;
      tick_valid <= in_window;
    end
  end

endmodule

[rtl/core/market_tick_line_parser.sv]
// Top level of the trade tick line parser: character stream in, one tick record out
// per line. Depends on mtlp_pkg, mtlp_cfg_regs, mtlp_field_accum and mtlp_out_reg.
//
//   channel   | direction | contents
//   s_t*      | in        | tdata[7:0] line_char, tlast end_of_line
//   m_t*      | out       | tdata: date, hour, minute, second_micros, price, volume
//             |           | tuser: tick_valid
//   cfg_*     | in        | write of open_hour (index 0) or close_hour (index 1)
//
// One character per clock cycle while s_tready is high; the accumulator update is the only step per character.
// A tick record appears on the output in the cycle after the transaction carrying tlast.
// Reset is synchronous and leaves the block ready for column 0 of a new line.
// Input is stalled only while a finished record waits and m_tready is low.
module market_tick_line_parser (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,  // [7:0] line_char
  input  logic                               s_tlast,  // end_of_line
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [26:0] trade_date, [33:27] trade_hour, [40:34] trade_minute,
  // [67:41] second_micros, [104:68] price_scaled, [135:105] trade_volume
  output logic [mtlp_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                               m_tuser,  // [0] tick_valid
  input  logic                               cfg_we,
  input  logic                               cfg_addr,
  input  logic [mtlp_pkg::CFG_W-1:0]         cfg_data
);
  import mtlp_pkg::*;

  hour_window_t window;
  line_fields_t fields_next;
  line_fields_t fields;
  logic         fire;

  assign s_tready = !m_tvalid || m_tready;
  assign fire     = s_tvalid && s_tready;

  mtlp_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .window   (window)
  );

  mtlp_field_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .line_char   (s_tdata),
    .end_of_line (s_tlast),
    .fields_next (fields_next)
  );

  mtlp_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (fire && s_tlast),
    .fields_next (fields_next),
    .window      (window),
    .take        (m_tready),
    .out_valid   (m_tvalid),
    .fields      (fields),
    .tick_valid  (m_tuser)
  );

  assign m_tdata = {fields.volume, fields.price, fields.second,
                    fields.minute, fields.hour, fields.date};

endmodule
